// File: rtl/core/b64c_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64c_pkg
// shared types, constants and alphabet functions of the base64 codec
// ----------------------------------------------------------------------------
package b64c_pkg;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);
  localparam int unsigned JobBytes   = 3;

  localparam logic [7:0] PadChar = 8'h3d;

  // register index taken from paddr[2]
  localparam logic RegIdxDecodeMode = 1'b0;

  typedef enum logic {
    MODE_ENCODE = 1'b0,
    MODE_DECODE = 1'b1
  } mode_e;

  // one queued job: up to three result beats
  typedef struct packed {
    logic [1:0]               last_idx;
    logic [JobBytes-1:0][7:0] data;
  } job_t;

  function automatic logic [7:0] enc_char(input logic [5:0] v);
    logic [7:0] r;
    if (v < 6'd26) begin
      r = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      r = 8'h61 + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      r = 8'h30 + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      r = 8'h2b;
    end else begin
      r = 8'h2f;
    end
    return r;
  endfunction

  // returns {valid, index}
  function automatic logic [6:0] dec_char(input logic [7:0] c);
    logic [6:0] r;
    if (c >= 8'h41 && c <= 8'h5a) begin
      r = {1'b1, 6'(c - 8'h41)};
    end else if (c >= 8'h61 && c <= 8'h7a) begin
      r = {1'b1, 6'(c - 8'h61 + 8'd26)};
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 6'(c - 8'h30 + 8'd52)};
    end else if (c == 8'h2b) begin
      r = {1'b1, 6'd62};
    end else if (c == 8'h2f) begin
      r = {1'b1, 6'd63};
    end else begin
      r = 7'd0;
    end
    return r;
  endfunction

endpackage

// File: rtl/core/b64c_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64c_front
// accepts input beats, updates the bit state and builds result jobs
// ----------------------------------------------------------------------------
module b64c_front import b64c_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  mode_e      mode_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       end_of_input_i,
  input  logic       q_full_i,
  output logic       q_push_o,
  output job_t       q_job_o
);

  // pending bit count in units of two bits
  logic [1:0] cnt_q, cnt_d;
  logic [5:0] bits_q, bits_d;
  logic       has_res;
  logic       accept;
  logic [6:0] dec;
  job_t       job;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign dec        = dec_char(in_byte_i);

  always_comb begin
    job     = '0;
    has_res = 1'b0;
    cnt_d   = cnt_q;
    bits_d  = bits_q;
    if (end_of_input_i) begin
      cnt_d  = 2'd0;
      bits_d = 6'd0;
      if (mode_i == MODE_ENCODE && cnt_q != 2'd0) begin
        has_res = 1'b1;
        unique case (cnt_q)
          2'd1: begin
            job.data[0]  = enc_char({bits_q[1:0], 4'b0000});
            job.data[1]  = PadChar;
            job.data[2]  = PadChar;
            job.last_idx = 2'd2;
          end
          2'd2: begin
            job.data[0]  = enc_char({bits_q[3:0], 2'b00});
            job.data[1]  = PadChar;
            job.last_idx = 2'd1;
          end
          default: begin
            job.data[0]  = enc_char(bits_q);
            job.last_idx = 2'd0;
          end
        endcase
      end
    end else if (mode_i == MODE_ENCODE) begin
      has_res = 1'b1;
      unique case (cnt_q)
        2'd0: begin
          job.data[0]  = enc_char(in_byte_i[7:2]);
          job.last_idx = 2'd0;
          cnt_d        = 2'd1;
          bits_d       = {4'b0000, in_byte_i[1:0]};
        end
        2'd1: begin
          job.data[0]  = enc_char({bits_q[1:0], in_byte_i[7:4]});
          job.last_idx = 2'd0;
          cnt_d        = 2'd2;
          bits_d       = {2'b00, in_byte_i[3:0]};
        end
        2'd2: begin
          job.data[0]  = enc_char({bits_q[3:0], in_byte_i[7:6]});
          job.data[1]  = enc_char(in_byte_i[5:0]);
          job.last_idx = 2'd1;
          cnt_d        = 2'd0;
          bits_d       = 6'd0;
        end
        default: begin
          job.data[0]  = enc_char(bits_q);
          job.data[1]  = enc_char(in_byte_i[7:2]);
          job.last_idx = 2'd1;
          cnt_d        = 2'd1;
          bits_d       = {4'b0000, in_byte_i[1:0]};
        end
      endcase
    end else if (dec[6]) begin
      unique case (cnt_q)
        2'd0: begin
          cnt_d  = 2'd3;
          bits_d = dec[5:0];
        end
        2'd1: begin
          has_res     = 1'b1;
          job.data[0] = {bits_q[1:0], dec[5:0]};
          cnt_d       = 2'd0;
          bits_d      = 6'd0;
        end
        2'd2: begin
          has_res     = 1'b1;
          job.data[0] = {bits_q[3:0], dec[5:2]};
          cnt_d       = 2'd1;
          bits_d      = {4'b0000, dec[1:0]};
        end
        default: begin
          has_res     = 1'b1;
          job.data[0] = {bits_q, dec[5:4]};
          cnt_d       = 2'd2;
          bits_d      = {2'b00, dec[3:0]};
        end
      endcase
    end
  end

  assign q_push_o = accept && has_res;
  assign q_job_o  = job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= 2'd0;
      bits_q <= 6'd0;
    end else if (accept) begin
      cnt_q  <= cnt_d;
      bits_q <= bits_d;
    end
  end

endmodule

// File: rtl/core/b64c_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64c_fifo
// short job queue between the front and back parts
// ----------------------------------------------------------------------------
module b64c_fifo import b64c_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t push_job_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output job_t pop_job_o
);

  job_t                 mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueueCntW-1:0] cnt_q;

  assign full_o    = cnt_q == QueueCntW'(QueueDepth);
  assign valid_o   = cnt_q != '0;
  assign pop_job_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// File: rtl/core/b64c_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64c_back
// unrolls queued jobs into output beats through an output register
// ----------------------------------------------------------------------------
module b64c_back import b64c_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_valid_i,
  input  job_t       q_job_i,
  output logic       q_pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       last_of_run_o
);

  job_t       cur_q;
  logic       cur_valid_q;
  logic [1:0] idx_q;
  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic       out_last_q;
  logic       adv;
  logic       is_last;
  logic [7:0] sel_byte;

  assign adv     = cur_valid_q && (!out_valid_q || out_ready_i);
  assign is_last = idx_q == cur_q.last_idx;
  assign q_pop_o = q_valid_i && (!cur_valid_q || (adv && is_last));

  always_comb begin
    unique case (idx_q)
      2'd0:    sel_byte = cur_q.data[0];
      2'd1:    sel_byte = cur_q.data[1];
      default: sel_byte = cur_q.data[2];
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cur_q <= q_job_i;
    end
    if (adv) begin
      out_byte_q <= sel_byte;
      out_last_q <= is_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      idx_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (q_pop_o) begin
        cur_valid_q <= 1'b1;
        idx_q       <= 2'd0;
      end else if (adv) begin
        if (is_last) begin
          cur_valid_q <= 1'b0;
        end
        idx_q <= idx_q + 2'd1;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = out_byte_q;
  assign last_of_run_o = out_last_q;

endmodule

// File: rtl/core/base64_codec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_codec
// streaming base64 encoder / decoder with an apb mode register
// path: a result beat passes through the job queue, the current-job register and the output register
// input: one beat per cycle while the two-entry job queue has room
// output: one beat per cycle while out_ready_i is high, so encoding sustains four beats per three bytes
// reset: bit state cleared, mode set to encode, queue and output emptied
// ----------------------------------------------------------------------------
module base64_codec import b64c_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  input  logic        end_of_input_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        last_of_run_o
);

  mode_e mode_q;
  logic  q_full, q_push, q_valid, q_pop;
  job_t  push_job, pop_job;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegIdxDecodeMode) ? {31'd0, mode_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_ENCODE;
    end else if (psel && penable && pwrite && paddr[2] == RegIdxDecodeMode) begin
      mode_q <= mode_e'(pwdata[0]);
    end
  end

  b64c_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .mode_i         (mode_q),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .in_byte_i      (in_byte_i),
    .end_of_input_i (end_of_input_i),
    .q_full_i       (q_full),
    .q_push_o       (q_push),
    .q_job_o        (push_job)
  );

  b64c_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_job_i (push_job),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .pop_job_o  (pop_job)
  );

  b64c_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_job_i       (pop_job),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_byte_o    (out_byte_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule
